### hdl/pted_pkg.sv
package pted_pkg;

  // Point coordinates are whole pixels of this many bits.
  localparam int COORD_BITS = 12;

  // Configuration register widths.
  localparam int CENTER_W = 18;
  localparam int AXIS_W   = 16;
  localparam int TRIG_W   = 16;
  localparam int CFG_W    = 18;
  localparam int IDX_W    = 3;

  // Output widths.
  localparam int DIST_W   = 18;
  localparam int STATUS_W = 2;

  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  // Register indexes on the configuration port.
  localparam logic [IDX_W-1:0] REG_CENTER_X = 3'd0;
  localparam logic [IDX_W-1:0] REG_CENTER_Y = 3'd1;
  localparam logic [IDX_W-1:0] REG_SEMI_A   = 3'd2;
  localparam logic [IDX_W-1:0] REG_SEMI_B   = 3'd3;
  localparam logic [IDX_W-1:0] REG_ROT_COS  = 3'd4;
  localparam logic [IDX_W-1:0] REG_ROT_SIN  = 3'd5;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_NORMAL    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_CENTER    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ZERO_AXIS = 2'd2;

  typedef struct packed {
    logic [COORD_BITS-1:0] px_x;
    logic [COORD_BITS-1:0] px_y;
  } pt_in_t;

  typedef struct packed {
    logic [DIST_W-1:0]   distance;
    logic [STATUS_W-1:0] status;
  } pt_out_t;

endpackage

### hdl/point_to_ellipse_distance_unit.sv
// Radial distance from an edge point to a rotated ellipse. The point, in
// whole pixels, is scaled to 1/16 pixel (FRAC_BITS fraction bits), moved by
// the configured center and rotated into the ellipse frame with the Q2.14
// cosine and sine. The ray from the center through the point is cut with the
// ellipse, and the beat out carries the gap between point and cut in 1/16
// pixel, saturated at its maximum, with a status: normal, point at the
// center (distance then equals semi_b), or a zero semi-axis (distance 0).
// The block is a fully pipelined datapath that accepts one beat per clock
// while the output is not stalled. RW = max(COORD_BITS + FRAC_BITS + 1, 18) + 4
// is the width of the rotated coordinates. The pipeline is mostly the two
// bit-per-stage square roots (one stage per root bit) and the 17-stage
// restoring divider that follows them. A stall at the output freezes the
// whole pipeline, so in_ready_o follows out_ready_i whenever the output
// register is full. Configuration registers are written through a plain
// write port and must only change while no beat is in flight.
module point_to_ellipse_distance_unit #(
  parameter int FRAC_BITS = 4
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,

  input  logic                    cfg_we_i,
  input  logic [pted_pkg::IDX_W-1:0] cfg_idx_i,
  input  logic [pted_pkg::CFG_W-1:0] cfg_wdata_i,

  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  pted_pkg::pt_in_t        in_data_i,

  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output pted_pkg::pt_out_t       out_data_o
);

  // Datapath widths, all derived from the coordinate format.
  localparam int XW   = pted_pkg::COORD_BITS + FRAC_BITS;
  localparam int NW   = ((XW + 1 > pted_pkg::CENTER_W) ? XW + 1 : pted_pkg::CENTER_W) + 1;
  localparam int PW   = NW + pted_pkg::TRIG_W;
  localparam int SW   = PW + 1;
  localparam int RW   = SW - 14;
  localparam int BU   = RW + pted_pkg::AXIS_W;
  localparam int HW   = (BU + 1) / 2;
  localparam int HIW  = BU - HW;
  localparam int B2   = 2 * BU;
  localparam int QW   = B2 + 2;
  localparam int QS   = QW / 2;
  localparam int R2W  = 2 * RW + 1;
  localparam int ABW  = 2 * pted_pkg::AXIS_W;
  localparam int TW   = ABW + RW + 1;
  localparam int EW   = pted_pkg::AXIS_W + 1;
  localparam int DW   = ((TW > QS + EW) ? TW : QS + EW) + 1;
  localparam int MW   = ((RW + 1 > EW) ? RW + 1 : EW) + 1;
  localparam int SQLAT = QS;

  // Configuration registers.
  logic signed [pted_pkg::CENTER_W-1:0] cx_q, cy_q;
  logic        [pted_pkg::AXIS_W-1:0]   a_q, b_q;
  logic signed [pted_pkg::TRIG_W-1:0]   cos_q, sin_q;
  logic        [ABW-1:0]                ab_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q  <= '0;
      cy_q  <= '0;
      a_q   <= pted_pkg::AXIS_W'(16);
      b_q   <= pted_pkg::AXIS_W'(16);
      cos_q <= pted_pkg::TRIG_W'(16384);
      sin_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        pted_pkg::REG_CENTER_X: cx_q  <= cfg_wdata_i;
        pted_pkg::REG_CENTER_Y: cy_q  <= cfg_wdata_i;
        pted_pkg::REG_SEMI_A:   a_q   <= cfg_wdata_i[pted_pkg::AXIS_W-1:0];
        pted_pkg::REG_SEMI_B:   b_q   <= cfg_wdata_i[pted_pkg::AXIS_W-1:0];
        pted_pkg::REG_ROT_COS:  cos_q <= cfg_wdata_i[pted_pkg::TRIG_W-1:0];
        pted_pkg::REG_ROT_SIN:  sin_q <= cfg_wdata_i[pted_pkg::TRIG_W-1:0];
        default: ;
      endcase
    end
  end

  // The product of the semi-axes only changes with configuration, so it is
  // kept ready in its own register.
  always_ff @(posedge clk_i) begin
    ab_q <= ABW'(a_q) * ABW'(b_q);
  end

  // A single advance signal moves every stage; a full output register that
  // is not being taken holds the whole pipeline.
  logic adv;
  logic out_valid_q;
  pted_pkg::pt_out_t out_data_q;

  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv;

  // Stage 1: scale the point and translate by the center.
  logic                 v1_q;
  logic signed [NW-1:0] nx_q, ny_q;
  logic        [XW-1:0] x_ext, y_ext;

  assign x_ext = XW'(in_data_i.px_x) << FRAC_BITS;
  assign y_ext = XW'(in_data_i.px_y) << FRAC_BITS;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      nx_q <= NW'(signed'({1'b0, x_ext})) - NW'(cx_q);
      ny_q <= NW'(signed'({1'b0, y_ext})) - NW'(cy_q);
    end
  end

  // Stage 2: the four rotation products.
  logic                 v2_q;
  logic signed [PW-1:0] pxc_q, pys_q, pyc_q, pxs_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pxc_q <= PW'(nx_q) * PW'(cos_q);
      pys_q <= PW'(ny_q) * PW'(sin_q);
      pyc_q <= PW'(ny_q) * PW'(cos_q);
      pxs_q <= PW'(nx_q) * PW'(sin_q);
    end
  end

  // Stage 3: rotated coordinates, still in Q14.
  logic                 v3_q;
  logic signed [SW-1:0] rxs_q, rys_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rxs_q <= SW'(pxc_q) + SW'(pys_q);
      rys_q <= SW'(pyc_q) - SW'(pxs_q);
    end
  end

  // Stage 4: round the magnitudes to whole units and classify the point.
  logic          v4_q;
  logic [SW-1:0] mx, my, mxr, myr;
  logic [RW-1:0] rx_q, ry_q;
  logic [RW-1:0] rx_d, ry_d;
  logic [pted_pkg::STATUS_W-1:0] st4_q, st4_d;

  assign mx   = rxs_q[SW-1] ? SW'(-rxs_q) : SW'(rxs_q);
  assign my   = rys_q[SW-1] ? SW'(-rys_q) : SW'(rys_q);
  assign mxr  = mx + SW'(8192);
  assign myr  = my + SW'(8192);
  assign rx_d = mxr[SW-1:14];
  assign ry_d = myr[SW-1:14];

  always_comb begin
    if (a_q == '0 || b_q == '0) begin
      st4_d = pted_pkg::ST_ZERO_AXIS;
    end else if (rx_d == '0 && ry_d == '0) begin
      st4_d = pted_pkg::ST_CENTER;
    end else begin
      st4_d = pted_pkg::ST_NORMAL;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rx_q  <= rx_d;
      ry_q  <= ry_d;
      st4_q <= st4_d;
    end
  end

  // Stage 5: axis-weighted coordinates and plain squares.
  logic           v5_q;
  logic [BU-1:0]  bu_q, av_q;
  logic [2*RW-1:0] rx2_q, ry2_q;
  logic [pted_pkg::STATUS_W-1:0] st5_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      bu_q  <= BU'(b_q) * BU'(rx_q);
      av_q  <= BU'(a_q) * BU'(ry_q);
      rx2_q <= (2*RW)'(rx_q) * (2*RW)'(rx_q);
      ry2_q <= (2*RW)'(ry_q) * (2*RW)'(ry_q);
      st5_q <= st4_q;
    end
  end

  // Stage 6: the wide squares are split into half-width partial products.
  logic              v6_q;
  logic [2*HIW-1:0]  buhh_q, avhh_q;
  logic [HIW+HW-1:0] buhl_q, avhl_q;
  logic [2*HW-1:0]   bull_q, avll_q;
  logic [R2W-1:0]    r2_6_q;
  logic [pted_pkg::STATUS_W-1:0] st6_q;
  logic [HIW-1:0]    bu_hi, av_hi;
  logic [HW-1:0]     bu_lo, av_lo;

  assign bu_hi = bu_q[BU-1:HW];
  assign bu_lo = bu_q[HW-1:0];
  assign av_hi = av_q[BU-1:HW];
  assign av_lo = av_q[HW-1:0];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      buhh_q <= (2*HIW)'(bu_hi) * (2*HIW)'(bu_hi);
      buhl_q <= (HIW+HW)'(bu_hi) * (HIW+HW)'(bu_lo);
      bull_q <= (2*HW)'(bu_lo) * (2*HW)'(bu_lo);
      avhh_q <= (2*HIW)'(av_hi) * (2*HIW)'(av_hi);
      avhl_q <= (HIW+HW)'(av_hi) * (HIW+HW)'(av_lo);
      avll_q <= (2*HW)'(av_lo) * (2*HW)'(av_lo);
      r2_6_q <= R2W'(rx2_q) + R2W'(ry2_q);
      st6_q  <= st5_q;
    end
  end

  // Stage 7: reassemble the two squares.
  logic           v7_q;
  logic [B2-1:0]  bu2_q, av2_q;
  logic [R2W-1:0] r2_7_q;
  logic [pted_pkg::STATUS_W-1:0] st7_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      bu2_q  <= (B2'(buhh_q) << (2 * HW)) + (B2'(buhl_q) << (HW + 1)) + B2'(bull_q);
      av2_q  <= (B2'(avhh_q) << (2 * HW)) + (B2'(avhl_q) << (HW + 1)) + B2'(avll_q);
      r2_7_q <= r2_6_q;
      st7_q  <= st6_q;
    end
  end

  // Stage 8: radicands for both square roots.
  logic          v8_q;
  logic [QW-1:0] qrad_q, rrad_q;
  logic [pted_pkg::STATUS_W-1:0] st8_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      qrad_q <= QW'(bu2_q) + QW'(av2_q);
      rrad_q <= QW'(r2_7_q);
      st8_q  <= st7_q;
    end
  end

  // Both roots run side by side in matching pipelines, so they come out
  // together; the status rides alongside.
  logic [QS-1:0] q_root, r_root;

  pted_sqrt #(.W(QW)) u_sqrt_q (
    .clk_i  (clk_i),
    .en_i   (adv),
    .rad_i  (qrad_q),
    .root_o (q_root)
  );

  pted_sqrt #(.W(QW)) u_sqrt_r (
    .clk_i  (clk_i),
    .en_i   (adv),
    .rad_i  (rrad_q),
    .root_o (r_root)
  );

  logic [SQLAT-1:0] sq_v_q;
  logic [pted_pkg::STATUS_W-1:0] sq_st_q [SQLAT];

  for (genvar i = 0; i < SQLAT; i++) begin : g_sq_side
    always_ff @(posedge clk_i) begin
      if (adv) begin
        sq_st_q[i] <= (i == 0) ? st8_q : sq_st_q[(i == 0) ? 0 : i - 1];
      end
    end
  end

  // Stage T: numerator of the intersection scale, a*b*r.
  logic          vt_q;
  logic [TW-1:0] t_q;
  logic [QS-1:0] qd_q;
  logic [RW:0]   rt_q;
  logic [pted_pkg::STATUS_W-1:0] stt_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      t_q   <= TW'(ab_q) * TW'(r_root[RW:0]);
      qd_q  <= q_root;
      rt_q  <= r_root[RW:0];
      stt_q <= sq_st_q[SQLAT-1];
    end
  end

  // Restoring divider, one quotient bit per stage. The quotient never
  // exceeds the larger semi-axis, which bounds its width.
  logic [EW-1:0] dv_v_q;
  logic [DW-1:0] dv_rem_q [EW];
  logic [QS-1:0] dv_q_q   [EW];
  logic [EW-1:0] dv_e_q   [EW];
  logic [RW:0]   dv_r_q   [EW];
  logic [pted_pkg::STATUS_W-1:0] dv_st_q [EW];

  for (genvar j = 0; j < EW; j++) begin : g_div
    localparam int K = EW - 1 - j;
    logic [DW-1:0] rem_in, den;
    logic [QS-1:0] q_in;
    logic [EW-1:0] e_in;
    logic [RW:0]   r_in;
    logic [pted_pkg::STATUS_W-1:0] st_in;

    if (j == 0) begin : g_first
      assign rem_in = DW'(t_q);
      assign q_in   = qd_q;
      assign e_in   = '0;
      assign r_in   = rt_q;
      assign st_in  = stt_q;
    end else begin : g_next
      assign rem_in = dv_rem_q[j-1];
      assign q_in   = dv_q_q[j-1];
      assign e_in   = dv_e_q[j-1];
      assign r_in   = dv_r_q[j-1];
      assign st_in  = dv_st_q[j-1];
    end

    assign den = DW'(q_in) << K;

    always_ff @(posedge clk_i) begin
      if (adv) begin
        if (rem_in >= den) begin
          dv_rem_q[j] <= rem_in - den;
          dv_e_q[j]   <= e_in | (EW'(1) << K);
        end else begin
          dv_rem_q[j] <= rem_in;
          dv_e_q[j]   <= e_in;
        end
        dv_q_q[j]  <= q_in;
        dv_r_q[j]  <= r_in;
        dv_st_q[j] <= st_in;
      end
    end
  end

  // Valid bits travel with the data through every stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      v4_q   <= 1'b0;
      v5_q   <= 1'b0;
      v6_q   <= 1'b0;
      v7_q   <= 1'b0;
      v8_q   <= 1'b0;
      sq_v_q <= '0;
      vt_q   <= 1'b0;
      dv_v_q <= '0;
    end else if (adv) begin
      v1_q   <= in_valid_i;
      v2_q   <= v1_q;
      v3_q   <= v2_q;
      v4_q   <= v3_q;
      v5_q   <= v4_q;
      v6_q   <= v5_q;
      v7_q   <= v6_q;
      v8_q   <= v7_q;
      sq_v_q <= SQLAT'({sq_v_q, v8_q});
      vt_q   <= sq_v_q[SQLAT-1];
      dv_v_q <= EW'({dv_v_q, vt_q});
    end
  end

  // Output stage: gap between point and cut, or the special-case value.
  logic [RW:0]   r_f;
  logic [EW-1:0] e_f;
  logic [MW-1:0] diff;
  logic [pted_pkg::DIST_W-1:0] dist_n;
  pted_pkg::pt_out_t out_d;

  assign r_f    = dv_r_q[EW-1];
  assign e_f    = dv_e_q[EW-1];
  assign diff   = (MW'(r_f) >= MW'(e_f)) ? MW'(r_f) - MW'(e_f) : MW'(e_f) - MW'(r_f);
  assign dist_n = (diff > MW'(pted_pkg::DIST_MAX)) ? pted_pkg::DIST_MAX
                                                    : pted_pkg::DIST_W'(diff);

  always_comb begin
    out_d.status = dv_st_q[EW-1];
    case (dv_st_q[EW-1])
      pted_pkg::ST_ZERO_AXIS: out_d.distance = '0;
      pted_pkg::ST_CENTER:    out_d.distance = pted_pkg::DIST_W'(b_q);
      default:                out_d.distance = dist_n;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= dv_v_q[EW-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_data_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

### hdl/pted_sqrt.sv
module pted_sqrt #(
  parameter int W = 80
) (
  input  logic           clk_i,
  input  logic           en_i,
  input  logic [W-1:0]   rad_i,
  output logic [W/2-1:0] root_o
);

  localparam int N = W / 2;

  // One result bit per stage, most significant first. Each stage keeps the
  // remainder of the radicand minus the square of the partial root.
  logic [W:0]   rem_q [N];
  logic [N-1:0] y_q   [N];

  for (genvar i = 0; i < N; i++) begin : g_stage
    localparam int K = N - 1 - i;
    logic [W:0]   rem_in;
    logic [N-1:0] y_in;
    logic [W:0]   trial;
    logic [W:0]   rem_d;
    logic [N-1:0] y_d;

    if (i == 0) begin : g_first
      assign rem_in = (W+1)'(rad_i);
      assign y_in   = '0;
    end else begin : g_next
      assign rem_in = rem_q[i-1];
      assign y_in   = y_q[i-1];
    end

    // Adding bit K to root y grows its square by (y << (K+1)) + (1 << 2K).
    assign trial = ((W+1)'(y_in) << (K + 1)) | ((W+1)'(1) << (2 * K));

    always_comb begin
      if (rem_in >= trial) begin
        rem_d = rem_in - trial;
        y_d   = y_in | (N'(1) << K);
      end else begin
        rem_d = rem_in;
        y_d   = y_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i] <= rem_d;
        y_q[i]   <= y_d;
      end
    end
  end

  assign root_o = y_q[N-1];

endmodule
